[rtl/core/odtp_pkg.sv]
// Shared types, constants and helpers of the one-shot delay timer pool.
package odtp_pkg;

    // Pool sizing
    localparam int SLOT_COUNT  = 10;
    localparam int DELAY_WIDTH = 16;
    localparam int TAG_WIDTH   = 8;

    // Fixed field widths on the ports
    localparam int ID_W       = 4;
    localparam int IN_DELAY_W = 16;
    localparam int IN_TAG_W   = 8;
    localparam int OUT_SLOT_W = 4;
    localparam int STATUS_W   = 3;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SAT_W      = (DELAY_WIDTH > IN_DELAY_W) ? DELAY_WIDTH : IN_DELAY_W;

    typedef logic [DELAY_WIDTH-1:0] t_delay;
    typedef logic [TAG_WIDTH-1:0]   t_tag;
    typedef logic [SLOT_IDX_W-1:0]  t_slot_idx;
    typedef logic [SLOT_COUNT-1:0]  t_slot_mask;
    typedef logic [STATUS_W-1:0]    t_status;

    localparam t_delay           DELAY_MAX     = {DELAY_WIDTH{1'b1}};
    localparam logic [SAT_W-1:0] DELAY_MAX_EXT = SAT_W'(DELAY_MAX);

    // Request function codes
    localparam logic FUNC_TICK     = 1'b0;
    localparam logic FUNC_REGISTER = 1'b1;

    // Result kinds
    localparam logic KIND_EXPIRY = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Registration status codes
    localparam t_status ST_SCHEDULED = 3'd0;
    localparam t_status ST_ID_USED   = 3'd1;
    localparam t_status ST_NO_SLOT   = 3'd2;
    localparam t_status ST_ZERO      = 3'd3;
    localparam t_status ST_BAD_ID    = 3'd4;

    // Controller to datapath
    typedef struct packed {
        logic accept_reg;
        logic accept_tick;
        logic load_reply;
        logic load_fire;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic fire_any;
    } t_sts;

    function automatic t_delay sat_delay(input logic [IN_DELAY_W-1:0] d);
        logic [SAT_W-1:0] ext;
        begin
            ext = SAT_W'(d);
            if (ext > DELAY_MAX_EXT) begin
                return DELAY_MAX;
            end
            return DELAY_WIDTH'(ext);
        end
    endfunction

    // Priority encoder: lowest set bit of a slot mask
    function automatic t_slot_idx lowest_index(input t_slot_mask m);
        t_slot_idx idx;
        begin
            idx = '0;
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                if (m[i]) begin
                    idx = SLOT_IDX_W'(i);
                end
            end
            return idx;
        end
    endfunction

endpackage

[rtl/core/odtp_ctrl.sv]
// Controller state machine of the timer pool: request intake and result sequencing.
module odtp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_func,
    output logic          o_in_stall,
    output odtp_pkg::t_cmd o_cmd,
    input  odtp_pkg::t_sts i_sts
);
    import odtp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_REPLY = 3'b010,
        S_SCAN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_func == FUNC_REGISTER) begin
                        o_cmd.accept_reg = 1'b1;
                        n_state          = S_REPLY;
                    end else begin
                        o_cmd.accept_tick = 1'b1;
                        n_state           = S_SCAN;
                    end
                end
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_reply = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN: begin
                // drain expiries one per cycle while the result register is free, lowest slot first
                if (!i_sts.fire_any) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.load_fire = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // No expiry may be left pending once new requests are taken
    a_idle_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.fire_any)
        else $error("expiry pending while idle");

endmodule

[rtl/core/odtp_datapath.sv]
// Datapath of the timer pool: slot counters, tags, id marks and the result register.
module odtp_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  odtp_pkg::t_cmd                   i_cmd,
    output odtp_pkg::t_sts                   o_sts,
    input  logic [odtp_pkg::ID_W-1:0]        i_request_id,
    input  logic [odtp_pkg::IN_DELAY_W-1:0]  i_delay_ticks,
    input  logic [odtp_pkg::IN_TAG_W-1:0]    i_action_tag,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic                             o_out_kind,
    output logic [odtp_pkg::IN_TAG_W-1:0]    o_out_fired_tag,
    output logic [odtp_pkg::OUT_SLOT_W-1:0]  o_out_slot_index,
    output logic [odtp_pkg::STATUS_W-1:0]    o_out_status,
    output logic                             o_out_last
);
    import odtp_pkg::*;

    t_delay     r_rem [SLOT_COUNT];
    t_delay     n_rem [SLOT_COUNT];
    t_tag       r_act [SLOT_COUNT];
    t_tag       n_act [SLOT_COUNT];
    t_slot_mask r_used;
    t_slot_mask n_used;
    t_slot_mask r_fire;
    t_slot_mask n_fire;
    t_slot_mask w_free;
    t_slot_mask w_running;

    logic      w_id_bad;
    t_slot_idx w_id_idx;
    t_delay    w_sat;
    t_slot_idx w_free_idx;
    t_status   w_status;
    t_slot_idx w_fire_idx;
    logic      w_fire_last;

    t_status   r_reply_status;
    t_slot_idx r_reply_slot;

    logic                  r_out_valid;
    logic                  r_out_kind;
    logic [IN_TAG_W-1:0]   r_out_tag;
    logic [OUT_SLOT_W-1:0] r_out_slot;
    t_status               r_out_status;
    logic                  r_out_last;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_free[i]    = (r_rem[i] == '0);
            w_running[i] = !w_free[i];
        end
    end

    assign w_id_bad   = ({1'b0, i_request_id} >= (ID_W + 1)'(SLOT_COUNT));
    assign w_id_idx   = i_request_id[SLOT_IDX_W-1:0];
    assign w_sat      = sat_delay(i_delay_ticks);
    assign w_free_idx = lowest_index(w_free);
    assign w_fire_idx = lowest_index(r_fire);

    always_comb begin
        w_fire_last             = 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (r_fire[i] && (SLOT_IDX_W'(i) != w_fire_idx)) begin
                w_fire_last = 1'b0;
            end
        end
    end

    always_comb begin
        if (w_id_bad) begin
            w_status = ST_BAD_ID;
        end else if (r_used[w_id_idx]) begin
            w_status = ST_ID_USED;
        end else if (w_sat == '0) begin
            w_status = ST_ZERO;
        end else if (w_free == '0) begin
            w_status = ST_NO_SLOT;
        end else begin
            w_status = ST_SCHEDULED;
        end
    end

    always_comb begin
        n_rem  = r_rem;
        n_act  = r_act;
        n_used = r_used;
        n_fire = r_fire;
        if (i_cmd.accept_reg) begin
            // mark the id even when nothing gets scheduled
            if (!w_id_bad && !r_used[w_id_idx]) begin
                n_used[w_id_idx] = 1'b1;
            end
            if (w_status == ST_SCHEDULED) begin
                n_rem[w_free_idx] = w_sat;
                n_act[w_free_idx] = TAG_WIDTH'(i_action_tag);
            end
        end
        if (i_cmd.accept_tick) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (w_running[i]) begin
                    n_rem[i] = r_rem[i] - 1'b1;
                    if (r_rem[i] == t_delay'(1) && r_act[i] != '0) begin
                        n_fire[i] = 1'b1;
                    end
                end
            end
        end
        if (i_cmd.load_fire) begin
            n_fire[w_fire_idx] = 1'b0;
            n_act[w_fire_idx]  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_rem[i] <= '0;
                r_act[i] <= '0;
            end
            r_used <= '0;
            r_fire <= '0;
        end else begin
            r_rem  <= n_rem;
            r_act  <= n_act;
            r_used <= n_used;
            r_fire <= n_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_reg) begin
            r_reply_status <= w_status;
            r_reply_slot   <= (w_status == ST_SCHEDULED) ? w_free_idx : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_reply || i_cmd.load_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_reply) begin
            r_out_kind   <= KIND_STATUS;
            r_out_tag    <= '0;
            r_out_slot   <= OUT_SLOT_W'(r_reply_slot);
            r_out_status <= r_reply_status;
            r_out_last   <= 1'b1;
        end else if (i_cmd.load_fire) begin
            r_out_kind   <= KIND_EXPIRY;
            r_out_tag    <= IN_TAG_W'(r_act[w_fire_idx]);
            r_out_slot   <= OUT_SLOT_W'(w_fire_idx);
            r_out_status <= ST_SCHEDULED;
            r_out_last   <= w_fire_last;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.fire_any = (r_fire != '0);

    assign o_out_valid      = r_out_valid;
    assign o_out_kind       = r_out_kind;
    assign o_out_fired_tag  = r_out_tag;
    assign o_out_slot_index = r_out_slot;
    assign o_out_status     = r_out_status;
    assign o_out_last       = r_out_last;

    // A slot waiting to report its expiry has already been freed
    a_fire_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fire & w_running) == '0)
        else $error("pending expiry on a running slot");

    // Never overwrite a result the consumer has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(i_cmd.load_reply || i_cmd.load_fire))
        else $error("result register overwritten while stalled");

    // A registration reply is always the only result of its request
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_STATUS) |-> r_out_last)
        else $error("status result without last");

endmodule

[rtl/core/oneshot_delay_timer_pool_top.sv]
// Top level of the one-shot delay timer pool.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+--------------------------------------
//   in      | sink      | i_in_valid / o_in_stall    | func, request_id, delay_ticks, action_tag
//   out     | source    | o_out_valid / i_out_stall  | kind, fired_tag, slot_index, status, last
//
// A register request checks the id and picks the lowest free slot in the accept cycle,
// then loads the status into the result register once that register is free.
// A tick request steps every running counter down in the accept cycle, then loads one
// expiry per cycle into the free result register, lowest slot first, until none is pending.
// One request is worked at a time; a stalled result register holds the sequencer in place.
// Reset clears all counters, tags and used-id marks at once; no clearing pass.
module oneshot_delay_timer_pool_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_in_func,
    input  logic [odtp_pkg::ID_W-1:0]        i_in_request_id,
    input  logic [odtp_pkg::IN_DELAY_W-1:0]  i_in_delay_ticks,
    input  logic [odtp_pkg::IN_TAG_W-1:0]    i_in_action_tag,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_out_kind,
    output logic [odtp_pkg::IN_TAG_W-1:0]    o_out_fired_tag,
    output logic [odtp_pkg::OUT_SLOT_W-1:0]  o_out_slot_index,
    output logic [odtp_pkg::STATUS_W-1:0]    o_out_status,
    output logic                             o_out_last
);
    import odtp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    odtp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_func),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    odtp_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_request_id     (i_in_request_id),
        .i_delay_ticks    (i_in_delay_ticks),
        .i_action_tag     (i_in_action_tag),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_kind       (o_out_kind),
        .o_out_fired_tag  (o_out_fired_tag),
        .o_out_slot_index (o_out_slot_index),
        .o_out_status     (o_out_status),
        .o_out_last       (o_out_last)
    );

endmodule
